### src/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property that holds in the same cycle.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg
// Command/status types and slope selector codes shared by the triangle
// scanline filler controller and datapath.
// ----------------------------------------------------------------------------
package tsf_pkg;

  // Which edge the shared divider works on.
  localparam logic [1:0] DIV_SEL_A = 2'd0;  // top to middle
  localparam logic [1:0] DIV_SEL_C = 2'd1;  // top to bottom (long edge)
  localparam logic [1:0] DIV_SEL_B = 2'd2;  // middle to bottom

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       mul;
    logic       step_top;
    logic       step_mid;
    logic       step_bot;
    logic       step_flat;
  } tsf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic flat;
    logic top_empty;
    logic top_end;
    logic mid_flat;
    logic bot_end;
    logic out_free;
  } tsf_status_t;

endpackage

### src/tsf_div.sv
// ----------------------------------------------------------------------------
// tsf_div
// Restoring divider, one quotient bit per cycle, for a 6-bit divisor.
// ----------------------------------------------------------------------------
module tsf_div #(
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [5:0]    divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW);
  localparam logic [CW-1:0] LastCnt = CW'(DW - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [5:0]    den_q, den_d;
  logic [5:0]    rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [6:0]    trial;
  logic          qbit;

  always_comb begin
    trial  = {rem_q, quo_q[DW-1]};
    qbit   = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = qbit ? 6'(trial - {1'b0, den_q}) : trial[5:0];
      quo_d = {quo_q[DW-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### src/tsf_datapath.sv
// ----------------------------------------------------------------------------
// tsf_datapath
// Vertex sort, slope registers, edge accumulators and the span output register.
// ----------------------------------------------------------------------------
module tsf_datapath import tsf_pkg::*; #(
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  vert0_x_i,
  input  logic [5:0]  vert0_y_i,
  input  logic [7:0]  vert1_x_i,
  input  logic [5:0]  vert1_y_i,
  input  logic [7:0]  vert2_x_i,
  input  logic [5:0]  vert2_y_i,
  input  logic [15:0] fill_color_i,
  input  tsf_cmd_t    cmd_i,
  output tsf_status_t status_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [5:0]  span_row_o,
  output logic [7:0]  span_x_a_o,
  output logic [7:0]  span_x_b_o,
  output logic [15:0] span_color_o,
  output logic        last_span_o
);

  localparam int unsigned DW = FRACTION_BITS + 8;
  localparam int unsigned SW = DW + 1;
  localparam int unsigned PW = FRACTION_BITS + 16;
  localparam int unsigned IW = PW - FRACTION_BITS;
  localparam logic [IW-1:0] XMax     = IW'(SCREEN_WIDTH - 1);
  localparam logic [6:0]    RowLimit = 7'(SCREEN_HEIGHT);
  localparam logic [5:0]    LastRow  = 6'(SCREEN_HEIGHT - 1);

  function automatic logic [7:0] edge_x(input logic signed [PW-1:0] p);
    logic [IW-1:0] v;
    v = p[PW-1:FRACTION_BITS];
    if (p[PW-1]) v = '0;
    else if (v > XMax) v = XMax;
    return v[7:0];
  endfunction

  function automatic logic signed [PW-1:0] fix_pos(input logic [7:0] x);
    return $signed({{(PW-8-FRACTION_BITS){1'b0}}, x, {FRACTION_BITS{1'b0}}});
  endfunction

  // Sorted vertices: top, middle, bottom.
  logic [7:0] tx_q, mx_q, bx_q;
  logic [5:0] ty_q, my_q, by_q;
  logic [15:0] color_q;
  logic [7:0] s0x, s1x, s2x, hx;
  logic [5:0] s0y, s1y, s2y, hy;

  // Stable insertion sort by row.
  always_comb begin
    hx = '0; hy = '0;
    s0x = vert0_x_i; s0y = vert0_y_i;
    s1x = vert1_x_i; s1y = vert1_y_i;
    s2x = vert2_x_i; s2y = vert2_y_i;
    if (s0y > s1y) begin
      hx = s0x; hy = s0y; s0x = s1x; s0y = s1y; s1x = hx; s1y = hy;
    end
    if (s1y > s2y) begin
      hx = s1x; hy = s1y; s1x = s2x; s1y = s2y; s2x = hx; s2y = hy;
    end
    if (s0y > s1y) begin
      hx = s0x; hy = s0y; s0x = s1x; s0y = s1y; s1x = hx; s1y = hy;
    end
  end

  // Divider operands.
  logic [7:0]    op_sx, op_ex;
  logic [5:0]    op_sy, op_ey, op_dy;
  logic [8:0]    op_dx, op_mag;
  logic [DW-1:0] div_quot;
  logic          div_done;
  logic signed [SW-1:0] slope_new;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SEL_A: begin op_sx = tx_q; op_ex = mx_q; op_sy = ty_q; op_ey = my_q; end
      DIV_SEL_C: begin op_sx = tx_q; op_ex = bx_q; op_sy = ty_q; op_ey = by_q; end
      default:   begin op_sx = mx_q; op_ex = bx_q; op_sy = my_q; op_ey = by_q; end
    endcase
    op_dx  = {1'b0, op_ex} - {1'b0, op_sx};
    op_mag = op_dx[8] ? 9'(-op_dx) : op_dx;
    op_dy  = op_ey - op_sy;
    if (op_dy == '0) slope_new = '0;
    else if (op_dx[8]) slope_new = -$signed({1'b0, div_quot});
    else slope_new = $signed({1'b0, div_quot});
  end

  tsf_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({op_mag[7:0], {FRACTION_BITS{1'b0}}}),
    .divisor_i  (op_dy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  logic signed [SW-1:0] sa_q, sb_q, sc_q;
  logic signed [PW-1:0] prod_b_q, prod_c_q, acc_a_q, acc_c_q;
  logic [5:0]           row_q, kb;
  logic [7:0]           lo_x, hi_x;

  assign kb = by_q - my_q - 6'd1;

  always_comb begin
    lo_x = tx_q;
    hi_x = tx_q;
    if (mx_q < lo_x) lo_x = mx_q;
    if (bx_q < lo_x) lo_x = bx_q;
    if (mx_q > hi_x) hi_x = mx_q;
    if (bx_q > hi_x) hi_x = bx_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tx_q <= s0x; ty_q <= s0y;
      mx_q <= s1x; my_q <= s1y;
      bx_q <= s2x; by_q <= s2y;
      color_q <= fill_color_i;
    end
    if (div_done) begin
      case (cmd_i.div_sel)
        DIV_SEL_A: sa_q <= slope_new;
        DIV_SEL_C: sc_q <= slope_new;
        default:   sb_q <= slope_new;
      endcase
    end
    if (cmd_i.mul) begin
      prod_b_q <= $signed({1'b0, kb}) * sb_q;
      prod_c_q <= $signed({1'b0, kb}) * sc_q;
      acc_a_q  <= fix_pos(tx_q);
      acc_c_q  <= fix_pos(tx_q);
      row_q    <= ty_q;
    end
    if (cmd_i.step_top) begin
      acc_a_q <= acc_a_q + PW'(sa_q);
      acc_c_q <= acc_c_q + PW'(sc_q);
      row_q   <= row_q + 6'd1;
    end
    if (cmd_i.step_mid) begin
      acc_a_q <= fix_pos(bx_q) - prod_b_q;
      acc_c_q <= fix_pos(bx_q) - prod_c_q;
      row_q   <= my_q + 6'd1;
    end
    if (cmd_i.step_bot) begin
      acc_a_q <= acc_a_q + PW'(sb_q);
      acc_c_q <= acc_c_q + PW'(sc_q);
      row_q   <= row_q + 6'd1;
    end
  end

  // Span output register.
  logic       emit;
  logic [5:0] e_row;
  logic [7:0] e_xa, e_xb;
  logic       out_valid_q, out_valid_d;
  logic [5:0] o_row_q;
  logic [7:0] o_xa_q, o_xb_q;
  logic [15:0] o_color_q;
  logic       o_last_q;

  assign emit = cmd_i.step_top | cmd_i.step_mid | cmd_i.step_bot | cmd_i.step_flat;

  always_comb begin
    e_row = row_q;
    e_xa  = edge_x(acc_a_q);
    e_xb  = edge_x(acc_c_q);
    if (cmd_i.step_mid) begin
      e_row = my_q;
      e_xa  = edge_x(fix_pos(mx_q));
      if (my_q == by_q) e_xb = edge_x(fix_pos(bx_q));
    end else if (cmd_i.step_flat) begin
      e_row = ty_q;
      e_xa  = edge_x(fix_pos(lo_x));
      e_xb  = edge_x(fix_pos(hi_x));
    end
    out_valid_d = out_valid_q;
    if (emit) out_valid_d = ({1'b0, e_row} < RowLimit);
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_row_q   <= e_row;
      o_xa_q    <= e_xa;
      o_xb_q    <= e_xb;
      o_color_q <= color_q;
      o_last_q  <= (e_row == by_q) || (e_row == LastRow);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign span_row_o   = o_row_q;
  assign span_x_a_o   = o_xa_q;
  assign span_x_b_o   = o_xb_q;
  assign span_color_o = o_color_q;
  assign last_span_o  = o_last_q;

  assign status_o.div_done  = div_done;
  assign status_o.flat      = (ty_q == by_q);
  assign status_o.top_empty = (ty_q == my_q);
  assign status_o.top_end   = (row_q + 6'd1 == my_q);
  assign status_o.mid_flat  = (my_q == by_q);
  assign status_o.bot_end   = (row_q == by_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### src/tsf_ctrl.sv
// ----------------------------------------------------------------------------
// tsf_ctrl
// Sequencer: sort/load, then a single span for a flat triangle, or three slope divisions, setup and one row per step.
// ----------------------------------------------------------------------------
module tsf_ctrl import tsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tsf_status_t status_i,
  output tsf_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIVGO = 4'd2;
  localparam logic [3:0] S_DIVWT = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_TOP   = 4'd5;
  localparam logic [3:0] S_MID   = 4'd6;
  localparam logic [3:0] S_BOT   = 4'd7;
  localparam logic [3:0] S_FLAT  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.div_sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        sel_d   = DIV_SEL_A;
        state_d = status_i.flat ? S_FLAT : S_DIVGO;
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVWT;
      end
      S_DIVWT: begin
        if (status_i.div_done) begin
          if (sel_q == DIV_SEL_B) begin
            state_d = S_MUL;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = S_DIVGO;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = status_i.top_empty ? S_MID : S_TOP;
      end
      S_TOP: begin
        if (status_i.out_free) begin
          cmd_o.step_top = 1'b1;
          if (status_i.top_end) state_d = S_MID;
        end
      end
      S_MID: begin
        if (status_i.out_free) begin
          cmd_o.step_mid = 1'b1;
          state_d = status_i.mid_flat ? S_IDLE : S_BOT;
        end
      end
      S_BOT: begin
        if (status_i.out_free) begin
          cmd_o.step_bot = 1'b1;
          if (status_i.bot_end) state_d = S_IDLE;
        end
      end
      S_FLAT: begin
        if (status_i.out_free) begin
          cmd_o.step_flat = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= DIV_SEL_A;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

### src/triangle_scanline_filler.sv
// Sequence: a triangle holds the sequencer through setup (accept, check, three
// slope divisions of start, DW steps and done on one shared radix-2 divider,
// product setup), then one covered row per cycle while the output is not stalled;
// a flat triangle takes accept, check and its single span.
// Throughput: one triangle at a time; a new one is accepted once the last span
// is in the output register. Output stalls hold the row stepper.
// Reset: asynchronous active-low, clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// triangle_scanline_filler
// Splits a triangle at its middle vertex and emits one span per covered row.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_scanline_filler import tsf_pkg::*; #(
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  vert0_x_i,
  input  logic [5:0]  vert0_y_i,
  input  logic [7:0]  vert1_x_i,
  input  logic [5:0]  vert1_y_i,
  input  logic [7:0]  vert2_x_i,
  input  logic [5:0]  vert2_y_i,
  input  logic [15:0] fill_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  span_row_o,
  output logic [7:0]  span_x_a_o,
  output logic [7:0]  span_x_b_o,
  output logic [15:0] span_color_o,
  output logic        last_span_o
);

  tsf_cmd_t    cmd;
  tsf_status_t status;
  logic        step_any;

  tsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tsf_datapath #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vert0_x_i    (vert0_x_i),
    .vert0_y_i    (vert0_y_i),
    .vert1_x_i    (vert1_x_i),
    .vert1_y_i    (vert1_y_i),
    .vert2_x_i    (vert2_x_i),
    .vert2_y_i    (vert2_y_i),
    .fill_color_i (fill_color_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .span_row_o   (span_row_o),
    .span_x_a_o   (span_x_a_o),
    .span_x_b_o   (span_x_b_o),
    .span_color_o (span_color_o),
    .last_span_o  (last_span_o)
  );

  assign step_any = cmd.step_top | cmd.step_mid | cmd.step_bot | cmd.step_flat;

  `ASSERT_CHK(a_no_step_idle, !(in_ready_o && step_any), "row step while idle")
  `ASSERT_CHK(a_step_needs_room, !step_any || status.out_free, "span overwrites a pending span")
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

endmodule
